// ===== hw/rtl/lne_pkg.sv =====
// ============================================================================
// lne_pkg: shared types and constants of the terminal line editor
// Command record passed from the front end to the back end, result record,
// character codes and capacity limits.
// ============================================================================
package lne_pkg;

    // character codes
    localparam logic [7:0] CharNul = 8'h00;
    localparam logic [7:0] CharBs  = 8'h08;
    localparam logic [7:0] CharNl  = 8'h0a;
    localparam logic [7:0] CharCr  = 8'h0d;
    localparam logic [7:0] CharSp  = 8'h20;
    localparam logic [7:0] CharDel = 8'h7f;

    // capacity limits (buffer bytes including the terminating zero)
    localparam logic [8:0] CapMin    = 9'd2;
    localparam logic [8:0] CapMax    = 9'd256;
    localparam logic [8:0] MaxLine   = 9'd256;
    localparam logic [8:0] CapReset  = 9'd128;

    // command queue depth
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    // command kinds decided by the front end
    typedef enum logic [2:0] {
        LNE_CR,          // carriage return: two results
        LNE_DEL_ECHO,    // delete with erase echo: three results
        LNE_DEL_SILENT,  // delete at line start: one result
        LNE_CHAR,        // plain character: one result
        LNE_CHAR_FULL    // character that fills the line: two results
    } lne_kind_t;

    typedef struct packed {
        lne_kind_t  kind;
        logic [7:0] ch;         // received character
        logic [7:0] pos;        // write position used for this character
        logic [7:0] aux_index;  // slot of the terminating zero on a full line
        logic [8:0] len;        // reported line length
    } lne_cmd_t;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_byte;
        logic       line_done;
        logic [8:0] line_length;
        logic       last;
    } lne_result_t;

endpackage

// ===== hw/rtl/lne_front.sv =====
// ============================================================================
// lne_front: input side of the line editor
// Holds the capacity register and the write position, classifies each
// received character and pushes one command per beat into the queue.
// ============================================================================
module lne_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [8:0]        cfg_data,
    input  logic              rx_valid,
    input  logic [7:0]        rx_char,
    output logic              rx_stall,
    input  logic              q_full,
    output logic              q_push,
    output lne_pkg::lne_cmd_t q_cmd
);

    logic [8:0] capacity_reg;
    logic [7:0] pos_reg;
    logic [7:0] pos_next;
    logic [8:0] cap;
    logic [7:0] lim;
    logic [7:0] lim_m1;
    logic [7:0] pos_sat;
    logic [8:0] pos_inc;
    logic       accept;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lne_pkg::CapReset;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_data;
        end
    end

    // effective capacity and limits
    always_comb
    begin
        cap = capacity_reg;
        if (cap < lne_pkg::CapMin)
        begin
            cap = lne_pkg::CapMin;
        end
        if (cap > lne_pkg::CapMax)
        begin
            cap = lne_pkg::CapMax;
        end
        if (cap > lne_pkg::MaxLine)
        begin
            cap = lne_pkg::MaxLine;
        end
    end

    assign lim     = 8'(cap - 9'd1);
    assign lim_m1  = lim - 8'd1;
    assign pos_sat = (pos_reg > lim_m1) ? lim_m1 : pos_reg;
    assign pos_inc = {1'b0, pos_sat} + 9'd1;

    assign rx_stall = q_full;
    assign accept   = rx_valid && !q_full;
    assign q_push   = accept;

    // classify the character and work out the next position
    always_comb
    begin
        q_cmd.ch        = rx_char;
        q_cmd.pos       = pos_sat;
        q_cmd.aux_index = lim;
        q_cmd.len       = 9'd0;
        q_cmd.kind      = lne_pkg::LNE_CHAR;
        pos_next        = pos_reg;
        if (rx_char == lne_pkg::CharCr)
        begin
            q_cmd.kind = lne_pkg::LNE_CR;
            q_cmd.len  = (pos_sat != 8'd0) ? pos_inc : 9'd0;
            pos_next   = 8'd0;
        end
        else if (rx_char == lne_pkg::CharDel)
        begin
            if (pos_sat != 8'd0)
            begin
                q_cmd.kind = lne_pkg::LNE_DEL_ECHO;
                pos_next   = pos_sat - 8'd1;
            end
            else
            begin
                q_cmd.kind = lne_pkg::LNE_DEL_SILENT;
                pos_next   = 8'd0;
            end
        end
        else if (pos_inc >= {1'b0, lim})
        begin
            q_cmd.kind = lne_pkg::LNE_CHAR_FULL;
            q_cmd.len  = cap;
            pos_next   = 8'd0;
        end
        else
        begin
            pos_next = pos_inc[7:0];
        end
    end

    // write position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 8'd0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== hw/rtl/lne_queue.sv =====
// ============================================================================
// lne_queue: command queue between front and back end
// Small register FIFO; push and pop may happen in the same cycle.
// ============================================================================
module lne_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lne_pkg::lne_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output lne_pkg::lne_cmd_t head_cmd
);

    localparam logic [lne_pkg::QueuePtrW:0] Depth = (lne_pkg::QueuePtrW + 1)'(lne_pkg::QueueDepth);

    lne_pkg::lne_cmd_t entry_reg [lne_pkg::QueueDepth];
    logic [lne_pkg::QueuePtrW-1:0] wr_ptr_reg;
    logic [lne_pkg::QueuePtrW-1:0] rd_ptr_reg;
    logic [lne_pkg::QueuePtrW:0]   count_reg;
    logic [lne_pkg::QueuePtrW:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign full       = (count_reg == Depth);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/lne_back.sv =====
// ============================================================================
// lne_back: result side of the line editor
// Expands each queued command into one to three results and holds the
// current result in an output register.
// ============================================================================
module lne_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  lne_pkg::lne_cmd_t    head_cmd,
    output logic                 pop,
    output logic                 res_valid,
    input  logic                 res_stall,
    output lne_pkg::lne_result_t res
);

    logic [1:0]           step_reg;
    logic [1:0]           step_next;
    logic                 valid_reg;
    lne_pkg::lne_result_t res_reg;
    lne_pkg::lne_result_t gen;
    logic                 load;
    logic                 echo_ch;

    assign echo_ch = (head_cmd.ch != lne_pkg::CharNul);

    // result for the current step of the head command
    always_comb
    begin
        gen = '0;
        unique case (head_cmd.kind) inside
            lne_pkg::LNE_CR:
            begin
                if (step_reg == 2'd0)
                begin
                    gen.echo_valid  = 1'b1;
                    gen.echo_byte   = lne_pkg::CharNl;
                    gen.store_valid = 1'b1;
                    gen.store_index = head_cmd.pos;
                end
                else
                begin
                    gen.echo_valid  = 1'b1;
                    gen.echo_byte   = lne_pkg::CharCr;
                    gen.line_done   = 1'b1;
                    gen.line_length = head_cmd.len;
                    gen.last        = 1'b1;
                end
            end
            lne_pkg::LNE_DEL_ECHO:
            begin
                gen.echo_valid = 1'b1;
                if (step_reg == 2'd0)
                begin
                    gen.echo_byte   = lne_pkg::CharBs;
                    gen.store_valid = 1'b1;
                    gen.store_index = head_cmd.pos;
                    gen.store_byte  = lne_pkg::CharDel;
                end
                else if (step_reg == 2'd1)
                begin
                    gen.echo_byte = lne_pkg::CharSp;
                end
                else
                begin
                    gen.echo_byte = lne_pkg::CharBs;
                    gen.last      = 1'b1;
                end
            end
            lne_pkg::LNE_DEL_SILENT:
            begin
                gen.store_valid = 1'b1;
                gen.store_byte  = lne_pkg::CharDel;
                gen.last        = 1'b1;
            end
            lne_pkg::LNE_CHAR, lne_pkg::LNE_CHAR_FULL:
            begin
                if (step_reg == 2'd0)
                begin
                    gen.echo_valid  = echo_ch;
                    gen.echo_byte   = head_cmd.ch;
                    gen.store_valid = 1'b1;
                    gen.store_index = head_cmd.pos;
                    gen.store_byte  = head_cmd.ch;
                    gen.last        = (head_cmd.kind == lne_pkg::LNE_CHAR);
                end
                else
                begin
                    gen.store_valid = 1'b1;
                    gen.store_index = head_cmd.aux_index;
                    gen.line_done   = 1'b1;
                    gen.line_length = head_cmd.len;
                    gen.last        = 1'b1;
                end
            end
            default:
            begin
                gen = '0;
            end
        endcase
    end

    // output register free or draining this cycle
    assign load = head_valid && (!valid_reg || !res_stall);
    assign pop  = load && gen.last;

    always_comb
    begin
        step_next = step_reg;
        if (load)
        begin
            step_next = gen.last ? 2'd0 : (step_reg + 2'd1);
        end
    end

    // step counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= gen;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/terminal_line_editor.sv =====
// ============================================================================
// terminal_line_editor: canonical line editing with echo for a terminal
// Front end classifies received characters, a command queue decouples it
// from the back end that emits buffer writes, echo bytes and line completion.
// ============================================================================
// Path: a character's command is registered in the command queue and its first
// result then in the output register, when queue and output register are free.
// Throughput: one result per cycle from the back end while res_stall is low; a
// character yields one to three results (three for an erase), the input takes
// a beat a cycle until the four-entry command queue fills.
// Reset: write position 0, capacity 128, queue and output register empty.
module terminal_line_editor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [8:0] cfg_data,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_char,
    output logic       res_valid,
    input  logic       res_stall,
    output logic       echo_valid,
    output logic [7:0] echo_byte,
    output logic       store_valid,
    output logic [7:0] store_index,
    output logic [7:0] store_byte,
    output logic       line_done,
    output logic [8:0] line_length,
    output logic       last
);

    logic                 q_full;
    logic                 q_push;
    lne_pkg::lne_cmd_t    q_cmd;
    logic                 q_pop;
    logic                 q_head_valid;
    lne_pkg::lne_cmd_t    q_head_cmd;
    lne_pkg::lne_result_t res;

    // input side
    lne_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .rx_valid (rx_valid),
        .rx_char  (rx_char),
        .rx_stall (rx_stall),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    // command queue
    lne_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // result side
    lne_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    // result fields
    assign echo_valid  = res.echo_valid;
    assign echo_byte   = res.echo_byte;
    assign store_valid = res.store_valid;
    assign store_index = res.store_index;
    assign store_byte  = res.store_byte;
    assign line_done   = res.line_done;
    assign line_length = res.line_length;
    assign last        = res.last;

endmodule
